@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define BRC_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous active-low reset.
`define BRC_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brc_pkg.sv @@
package brc_pkg;

  // Default parameter values.
  localparam int PWM_BITS_DEF      = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN_P    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN_D    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_P    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN_I = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN_D     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE_MV  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_PERIOD    = 4'd7;

  // Register reset values.
  localparam logic [15:0] RST_PITCH_GAIN_P    = 16'd14080;
  localparam logic [15:0] RST_PITCH_GAIN_D    = 16'd192;
  localparam logic [15:0] RST_SPEED_GAIN_P    = 16'd2560;
  localparam logic [15:0] RST_POSITION_GAIN_I = 16'd67;
  localparam logic [15:0] RST_TURN_GAIN_D     = 16'd128;
  localparam logic [13:0] RST_MIN_VOLTAGE_MV  = 14'd6000;
  localparam logic [15:0] RST_POSITION_LIMIT  = 16'd3000;
  localparam logic [7:0]  RST_OUTER_PERIOD    = 8'd8;

  // Microprogram geometry.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_MIX  = 5'd15;
  localparam logic [STEP_W-1:0] ST_STOP = 5'd16;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_PEND,
    OP_TRAVEL,
    OP_PITCH,
    OP_SPEED,
    OP_FILT,
    OP_INTEG,
    OP_POSTERM,
    OP_YAW,
    OP_MIX,
    OP_STOP
  } op_t;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    MA_ANGLE,
    MA_PRATE,
    MA_YRATE,
    MA_SF,
    MA_PI,
    MA_SUM
  } mula_t;

  typedef enum logic [2:0] {
    MB_KP,
    MB_KD,
    MB_SGP,
    MB_PGI,
    MB_KT,
    MB_KEEP,
    MB_NEW
  } mulb_t;

  // Accumulator actions on the registered product.
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADDSH
  } acc_t;

  // Jump conditions.
  typedef enum logic [1:0] {
    CND_NONE,
    CND_LOWV,
    CND_NOT_OUTER
  } cond_t;

  typedef struct packed {
    op_t               op;
    mula_t             ma;
    mulb_t             mb;
    acc_t              acc;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    logic low_volt;
    logic outer_due;
    logic out_hold;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    op: OP_NOP, ma: MA_ANGLE, mb: MB_KP, acc: ACC_NONE,
    cond: CND_NONE, target: '0, last: 1'b0
  };

  // Control store. Products are registered, so a step that accumulates
  // uses the product selected one step earlier.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (step)
      5'd0: begin
        c.op = OP_PEND; c.cond = CND_LOWV; c.target = ST_STOP;
      end
      5'd1: begin
        c.op = OP_TRAVEL; c.ma = MA_ANGLE; c.mb = MB_KP;
      end
      5'd2: begin
        c.ma = MA_PRATE; c.mb = MB_KD; c.acc = ACC_LOAD;
      end
      5'd3: begin
        c.acc = ACC_ADD;
      end
      5'd4: begin
        c.op = OP_PITCH; c.cond = CND_NOT_OUTER; c.target = ST_MIX;
      end
      5'd5: begin
        c.op = OP_SPEED; c.ma = MA_SF; c.mb = MB_KEEP;
      end
      5'd6: begin
        c.ma = MA_SUM; c.mb = MB_NEW; c.acc = ACC_LOAD;
      end
      5'd7: begin
        c.acc = ACC_ADDSH;
      end
      5'd8: begin
        c.op = OP_FILT;
      end
      5'd9: begin
        c.op = OP_INTEG; c.ma = MA_SF; c.mb = MB_SGP;
      end
      5'd10: begin
        c.ma = MA_PI; c.mb = MB_PGI; c.acc = ACC_LOAD;
      end
      5'd11: begin
        c.acc = ACC_ADD;
      end
      5'd12: begin
        c.op = OP_POSTERM; c.ma = MA_YRATE; c.mb = MB_KT;
      end
      5'd13: begin
        c.acc = ACC_LOAD;
      end
      5'd14: begin
        c.op = OP_YAW;
      end
      5'd15: begin
        c.op = OP_MIX; c.last = 1'b1;
      end
      5'd16: begin
        c.op = OP_STOP; c.last = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/brc_ifs.sv @@
// Input item channel.
interface brc_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pitch_estimate;
  logic signed [16:0] pitch_rate;
  logic signed [16:0] yaw_rate;
  logic [7:0]         left_pulses;
  logic [7:0]         right_pulses;
  logic signed [15:0] target_speed;
  logic signed [15:0] target_turn;
  logic [13:0]        battery_mv;

  modport source (
    output valid, pitch_estimate, pitch_rate, yaw_rate, left_pulses, right_pulses,
           target_speed, target_turn, battery_mv,
    input  ready
  );
  modport sink (
    input  valid, pitch_estimate, pitch_rate, yaw_rate, left_pulses, right_pulses,
           target_speed, target_turn, battery_mv,
    output ready
  );
endinterface

// Result item channel.
interface brc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;
  logic               stopped;
  logic               outer_updated;

  modport source (
    output valid, left_drive, right_drive, stopped, outer_updated,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, stopped, outer_updated,
    output ready
  );
endinterface

@@ rtl/brc_seq.sv @@
module brc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  brc_pkg::status_t status,
  output brc_pkg::ctrl_t   ctrl,
  output logic             idle
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                   state_r, state_nxt;
  logic [brc_pkg::STEP_W-1:0]   step_r, step_nxt;
  brc_pkg::ctrl_t               word;
  logic                         stall;
  logic                         take;

  // Fetch the control word, resolve the jump and pick the next step.
  always_comb begin
    word  = brc_pkg::ucode(step_r);
    stall = word.last && status.out_hold;
    unique case (word.cond)
      brc_pkg::CND_NONE:      take = 1'b0;
      brc_pkg::CND_LOWV:      take = status.low_volt;
      brc_pkg::CND_NOT_OUTER: take = !status.outer_due;
      default:                take = 1'b0;
    endcase

    state_nxt = state_r;
    step_nxt  = step_r;
    ctrl      = word;
    unique case (state_r)
      SQ_IDLE: begin
        ctrl.op  = brc_pkg::OP_NOP;
        ctrl.acc = brc_pkg::ACC_NONE;
        if (start) begin
          state_nxt = SQ_RUN;
          step_nxt  = '0;
        end
      end
      SQ_RUN: begin
        if (stall) begin
          // The result register is still full: hold the final step.
          ctrl.op  = brc_pkg::OP_NOP;
          ctrl.acc = brc_pkg::ACC_NONE;
        end else if (word.last) begin
          state_nxt = SQ_IDLE;
        end else if (take) begin
          step_nxt = word.target;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign idle = (state_r == SQ_IDLE);

endmodule

@@ rtl/brc_datapath.sv @@
module brc_datapath #(
  parameter int PWM_BITS      = brc_pkg::PWM_BITS_DEF,
  parameter int FRACTION_BITS = brc_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic signed [16:0]              pitch_estimate,
  input  logic signed [16:0]              pitch_rate,
  input  logic signed [16:0]              yaw_rate,
  input  logic [7:0]                      left_pulses,
  input  logic [7:0]                      right_pulses,
  input  logic signed [15:0]              target_speed,
  input  logic signed [15:0]              target_turn,
  input  logic [13:0]                     battery_mv,
  input  brc_pkg::ctrl_t                  ctrl,
  output brc_pkg::status_t                status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [15:0]              left_drive,
  output logic signed [15:0]              right_drive,
  output logic                            stopped,
  output logic                            outer_updated
);

  localparam int F      = FRACTION_BITS;
  localparam int KEEP   = (7 * (1 << FRACTION_BITS) + 5) / 10;
  localparam int NEWW   = (1 << FRACTION_BITS) - KEEP;
  localparam int MIX_W  = 36;

  localparam logic signed [17:0] KEEP_B  = 18'(KEEP);
  localparam logic signed [17:0] NEW_B   = 18'(NEWW);
  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -I32_MAX - 64'sd1;
  localparam logic signed [63:0] T24_MAX = 64'sd8388607;
  localparam logic signed [63:0] T24_MIN = -T24_MAX - 64'sd1;
  localparam logic signed [63:0] PWM_MAX = (64'sd1 <<< (PWM_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] PWM_MIN = -PWM_MAX - 64'sd1;

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    logic signed [63:0] r;
    r = x;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] kp_r, kd_r, sgp_r, pgi_r, kt_r, plim_r;
  logic [13:0] minv_r;
  logic [7:0]  period_r;

  // Latched input item.
  logic signed [16:0] angle_r, prate_r, yrate_r;
  logic [7:0]         lp_r, rp_r;
  logic signed [15:0] tspeed_r, tturn_r;
  logic [13:0]        batt_r;

  // Controller state.
  logic [15:0]        pend_lt_r, pend_rt_r;
  logic signed [23:0] trav_lt_r, trav_rt_r;
  logic               rev_lt_r, rev_rt_r;
  logic signed [31:0] sf_r, pi_r, pt_r, yaw_r;
  logic [7:0]         tick_r;

  // Working registers.
  logic signed [49:0]      prod_r;
  logic signed [63:0]      acc_r;
  logic signed [MIX_W-1:0] pitch_r;
  logic signed [24:0]      sum_r;
  logic                    outer_r;

  // Result register.
  logic               out_valid_r;
  logic signed [15:0] out_left_r, out_right_r;
  logic               out_stop_r, out_outer_r;

  // Combinational next values.
  logic [16:0]             pend_lt_sum, pend_rt_sum;
  logic [15:0]             pend_lt_nxt, pend_rt_nxt;
  logic signed [16:0]      delta_lt, delta_rt;
  logic signed [25:0]      trav_lt_sum, trav_rt_sum;
  logic signed [23:0]      trav_lt_nxt, trav_rt_nxt;
  logic [7:0]              eff_period;
  logic signed [31:0]      mul_a;
  logic signed [17:0]      mul_b;
  logic signed [49:0]      prod_nxt;
  logic signed [63:0]      acc_nxt;
  logic [63:0]             lim_raw;
  logic signed [63:0]      lim_pos;
  logic signed [63:0]      integ_sum;
  logic signed [31:0]      sf_nxt, pi_nxt, pt_nxt, yaw_nxt;
  logic signed [MIX_W-1:0] left_mix, right_mix;
  logic signed [63:0]      left_sat, right_sat;

  // Pending pulse counts saturate at the top of their range.
  always_comb begin
    pend_lt_sum = {1'b0, pend_lt_r} + 17'(lp_r);
    pend_rt_sum = {1'b0, pend_rt_r} + 17'(rp_r);
    pend_lt_nxt = pend_lt_sum[16] ? 16'hFFFF : pend_lt_sum[15:0];
    pend_rt_nxt = pend_rt_sum[16] ? 16'hFFFF : pend_rt_sum[15:0];
  end

  // Travel takes the pending pulses signed by the last drive direction.
  always_comb begin
    delta_lt    = rev_lt_r ? -$signed({1'b0, pend_lt_r}) : $signed({1'b0, pend_lt_r});
    delta_rt    = rev_rt_r ? -$signed({1'b0, pend_rt_r}) : $signed({1'b0, pend_rt_r});
    trav_lt_sum = 26'(trav_lt_r) + 26'(delta_lt);
    trav_rt_sum = 26'(trav_rt_r) + 26'(delta_rt);
    trav_lt_nxt = 24'(clamp64(64'(trav_lt_sum), T24_MIN, T24_MAX));
    trav_rt_nxt = 24'(clamp64(64'(trav_rt_sum), T24_MIN, T24_MAX));
  end

  // Shared multiplier operands.
  always_comb begin
    case (ctrl.ma)
      brc_pkg::MA_ANGLE: mul_a = 32'(angle_r);
      brc_pkg::MA_PRATE: mul_a = 32'(prate_r);
      brc_pkg::MA_YRATE: mul_a = 32'(yrate_r);
      brc_pkg::MA_SF:    mul_a = sf_r;
      brc_pkg::MA_PI:    mul_a = pi_r;
      brc_pkg::MA_SUM:   mul_a = 32'(sum_r);
      default:           mul_a = '0;
    endcase
    case (ctrl.mb)
      brc_pkg::MB_KP:   mul_b = $signed({2'b00, kp_r});
      brc_pkg::MB_KD:   mul_b = $signed({2'b00, kd_r});
      brc_pkg::MB_SGP:  mul_b = $signed({2'b00, sgp_r});
      brc_pkg::MB_PGI:  mul_b = $signed({2'b00, pgi_r});
      brc_pkg::MB_KT:   mul_b = $signed({2'b00, kt_r});
      brc_pkg::MB_KEEP: mul_b = KEEP_B;
      brc_pkg::MB_NEW:  mul_b = NEW_B;
      default:          mul_b = '0;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Accumulator on the registered product.
  always_comb begin
    case (ctrl.acc)
      brc_pkg::ACC_LOAD:  acc_nxt = 64'(prod_r);
      brc_pkg::ACC_ADD:   acc_nxt = acc_r + 64'(prod_r);
      brc_pkg::ACC_ADDSH: acc_nxt = acc_r + (64'(prod_r) <<< (F - 1));
      default:            acc_nxt = acc_r;
    endcase
  end

  // Outer loop results, each saturated to 32 bits.
  always_comb begin
    lim_raw   = 64'(plim_r) << F;
    lim_pos   = (lim_raw > 64'(I32_MAX)) ? I32_MAX : $signed(lim_raw);
    integ_sum = 64'(pi_r) + 64'(sf_r) - 64'(tspeed_r);
    sf_nxt    = 32'(clamp64(acc_r >>> F, I32_MIN, I32_MAX));
    pi_nxt    = 32'(clamp64(integ_sum, -lim_pos, lim_pos));
    pt_nxt    = 32'(clamp64((-acc_r) >>> (2 * F), I32_MIN, I32_MAX));
    yaw_nxt   = 32'(clamp64(64'(tturn_r) + (acc_r >>> (2 * F)), I32_MIN, I32_MAX));
  end

  // Drive mix and saturation to the PWM range.
  always_comb begin
    left_mix  = pitch_r - MIX_W'(yaw_r) - MIX_W'(pt_r);
    right_mix = pitch_r + MIX_W'(yaw_r) - MIX_W'(pt_r);
    left_sat  = clamp64(64'(left_mix), PWM_MIN, PWM_MAX);
    right_sat = clamp64(64'(right_mix), PWM_MIN, PWM_MAX);
  end

  // Status for the sequencer; period zero runs the loops every tick.
  always_comb begin
    eff_period       = (period_r == 8'd0) ? 8'd1 : period_r;
    status.low_volt  = (batt_r <= minv_r);
    status.outer_due = (tick_r >= eff_period);
    status.out_hold  = out_valid_r && !out_ready;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= brc_pkg::RST_PITCH_GAIN_P;
      kd_r     <= brc_pkg::RST_PITCH_GAIN_D;
      sgp_r    <= brc_pkg::RST_SPEED_GAIN_P;
      pgi_r    <= brc_pkg::RST_POSITION_GAIN_I;
      kt_r     <= brc_pkg::RST_TURN_GAIN_D;
      minv_r   <= brc_pkg::RST_MIN_VOLTAGE_MV;
      plim_r   <= brc_pkg::RST_POSITION_LIMIT;
      period_r <= brc_pkg::RST_OUTER_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        brc_pkg::REG_PITCH_GAIN_P:    kp_r     <= cfg_data;
        brc_pkg::REG_PITCH_GAIN_D:    kd_r     <= cfg_data;
        brc_pkg::REG_SPEED_GAIN_P:    sgp_r    <= cfg_data;
        brc_pkg::REG_POSITION_GAIN_I: pgi_r    <= cfg_data;
        brc_pkg::REG_TURN_GAIN_D:     kt_r     <= cfg_data;
        brc_pkg::REG_MIN_VOLTAGE_MV:  minv_r   <= cfg_data[13:0];
        brc_pkg::REG_POSITION_LIMIT:  plim_r   <= cfg_data;
        brc_pkg::REG_OUTER_PERIOD:    period_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input item latch and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      angle_r  <= pitch_estimate;
      prate_r  <= pitch_rate;
      yrate_r  <= yaw_rate;
      lp_r     <= left_pulses;
      rp_r     <= right_pulses;
      tspeed_r <= target_speed;
      tturn_r  <= target_turn;
      batt_r   <= battery_mv;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctrl.op == brc_pkg::OP_PITCH) pitch_r <= MIX_W'(acc_r >>> (2 * F));
    if (ctrl.op == brc_pkg::OP_SPEED) sum_r <= 25'(trav_lt_r) + 25'(trav_rt_r);
    if (ctrl.op == brc_pkg::OP_MIX) begin
      out_left_r  <= left_sat[15:0];
      out_right_r <= right_sat[15:0];
      out_stop_r  <= 1'b0;
      out_outer_r <= outer_r;
    end else if (ctrl.op == brc_pkg::OP_STOP) begin
      out_left_r  <= '0;
      out_right_r <= '0;
      out_stop_r  <= 1'b1;
      out_outer_r <= 1'b0;
    end
  end

  // Controller state, updated by the operation of the current step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_lt_r   <= '0;
      pend_rt_r   <= '0;
      trav_lt_r   <= '0;
      trav_rt_r   <= '0;
      rev_lt_r    <= 1'b0;
      rev_rt_r    <= 1'b0;
      sf_r        <= '0;
      pi_r        <= '0;
      pt_r        <= '0;
      yaw_r       <= '0;
      tick_r      <= '0;
      outer_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result fills the output register; a taken one empties it.
      if (ctrl.op == brc_pkg::OP_MIX || ctrl.op == brc_pkg::OP_STOP) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctrl.op)
        brc_pkg::OP_PEND: begin
          pend_lt_r <= pend_lt_nxt;
          pend_rt_r <= pend_rt_nxt;
          outer_r   <= 1'b0;
        end
        brc_pkg::OP_TRAVEL: begin
          trav_lt_r <= trav_lt_nxt;
          trav_rt_r <= trav_rt_nxt;
          pend_lt_r <= '0;
          pend_rt_r <= '0;
          tick_r    <= tick_r + 8'd1;
        end
        brc_pkg::OP_SPEED: begin
          trav_lt_r <= '0;
          trav_rt_r <= '0;
          tick_r    <= '0;
          outer_r   <= 1'b1;
        end
        brc_pkg::OP_FILT:    sf_r  <= sf_nxt;
        brc_pkg::OP_INTEG:   pi_r  <= pi_nxt;
        brc_pkg::OP_POSTERM: pt_r  <= pt_nxt;
        brc_pkg::OP_YAW:     yaw_r <= yaw_nxt;
        brc_pkg::OP_MIX: begin
          rev_lt_r <= left_sat[63];
          rev_rt_r <= right_sat[63];
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign left_drive    = out_left_r;
  assign right_drive   = out_right_r;
  assign stopped       = out_stop_r;
  assign outer_updated = out_outer_r;

endmodule

@@ rtl/balance_robot_cascaded_control.sv @@
// Cascaded balance controller for a two-wheeled robot: each input item is one
// control tick and yields exactly one result item with both wheel drives. A
// small microprogram steps one shared 32 by 18 bit multiplier and a 64-bit
// accumulator through the pitch PD law every tick and, every outer_period
// ticks, through the wheel speed filter, the clamped position integral, the
// PI law and the yaw term. A low-battery stop jumps from the first step to the
// stop step, an ordinary tick skips from the pitch step to the mix step, and a
// tick that runs the outer loops walks every step up to the mix step; the next
// item is taken once the sequencer is idle again. The finished result waits in
// an output register, so a stalled consumer holds the block only at the last
// step of the following item.
// Configuration writes are taken at any time but are meant for an idle block.
module balance_robot_cascaded_control #(
  parameter int PWM_BITS      = brc_pkg::PWM_BITS_DEF,
  parameter int FRACTION_BITS = brc_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  brc_in_if.sink                         in_chan,
  brc_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0] cfg_data
);

  brc_pkg::ctrl_t   ctrl;
  brc_pkg::status_t status;
  logic             idle;
  logic             accept;

  // An item is taken only while the sequencer is idle.
  assign in_chan.ready = idle;
  assign accept        = in_chan.valid && idle;

  brc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .status (status),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  brc_datapath #(
    .PWM_BITS      (PWM_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .pitch_estimate (in_chan.pitch_estimate),
    .pitch_rate     (in_chan.pitch_rate),
    .yaw_rate       (in_chan.yaw_rate),
    .left_pulses    (in_chan.left_pulses),
    .right_pulses   (in_chan.right_pulses),
    .target_speed   (in_chan.target_speed),
    .target_turn    (in_chan.target_turn),
    .battery_mv     (in_chan.battery_mv),
    .ctrl           (ctrl),
    .status         (status),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .left_drive     (out_chan.left_drive),
    .right_drive    (out_chan.right_drive),
    .stopped        (out_chan.stopped),
    .outer_updated  (out_chan.outer_updated)
  );

endmodule

@@ rtl/brc_checker.sv @@
`include "assert_macros.svh"

module brc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] left_drive,
  input logic signed [15:0] right_drive,
  input logic               stopped,
  input logic               outer_updated
);

  // A stop result carries zero drives and never reports an outer update.
  `BRC_ASSERT_IMP(a_stop_zero, clk, rst_n, out_valid && stopped,
    left_drive == 16'sd0 && right_drive == 16'sd0 && !outer_updated,
    "stop result with nonzero drive or outer flag")

  // Once an item is taken, the block works on it before taking another.
  `BRC_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready,
    "input taken while an item is still in progress")

  // A result that is not taken stays offered.
  `BRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
    "result withdrawn before it was taken")

  // A stalled result keeps its payload.
  `BRC_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
    $stable(left_drive) && $stable(right_drive) && $stable(stopped)
      && $stable(outer_updated),
    "stalled result changed")

endmodule

bind balance_robot_cascaded_control brc_checker u_brc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .left_drive    (out_chan.left_drive),
  .right_drive   (out_chan.right_drive),
  .stopped       (out_chan.stopped),
  .outer_updated (out_chan.outer_updated)
);
